>>> src/nggp_pkg.sv
// Shared types, character codes and weight tables for the GGA sentence parser.
`timescale 1ns / 1ps
`default_nettype none
package nggp_pkg;

  localparam logic [7:0] EndByteReset = 8'd10;
  localparam logic [7:0] CharComma    = 8'h2C;
  localparam logic [7:0] CharPlus     = 8'h2B;
  localparam logic [7:0] CharMinus    = 8'h2D;
  localparam logic [7:0] CharDot      = 8'h2E;
  localparam logic [7:0] CharZero     = 8'h30;
  localparam logic [7:0] CharNine     = 8'h39;
  localparam logic [7:0] CharG        = 8'h47;
  localparam logic [7:0] CharA        = 8'h41;
  localparam logic [7:0] CharN        = 8'h4E;
  localparam logic [7:0] CharE        = 8'h45;

  localparam logic [3:0] FldType    = 4'd0;
  localparam logic [3:0] FldTime    = 4'd1;
  localparam logic [3:0] FldLat     = 4'd2;
  localparam logic [3:0] FldLatHemi = 4'd3;
  localparam logic [3:0] FldLon     = 4'd4;
  localparam logic [3:0] FldLonHemi = 4'd5;
  localparam logic [3:0] FldQuality = 4'd6;
  localparam logic [3:0] FldSats    = 4'd7;
  localparam logic [3:0] FldAlt     = 4'd9;
  localparam logic [3:0] FldLast    = 4'd15;

  localparam logic [7:0] PosLast    = 8'd255;
  localparam logic [7:0] TypeLength = 8'd6;

  // altitude fraction tracking: integer part, fraction digits 1..3 taken, stopped
  localparam logic [2:0] AltInt     = 3'd0;
  localparam logic [2:0] AltFracEnd = 3'd4;
  localparam logic [2:0] AltStop    = 3'd7;
  localparam logic [26:0] AltMax    = 27'd99999999;

  typedef struct packed {
    logic       take;      // ordinary character step
    logic       done;      // end byte step
    logic [3:0] field;
    logic [7:0] pos;
    logic [7:0] ch;
    logic       is_digit;
    logic [3:0] digit;
  } tok_t;

  typedef struct packed {
    logic [6:0]  hour;
    logic [6:0]  minute;
    logic [6:0]  second;
    logic [25:0] lat;
    logic        lat_present;
    logic        lat_north;
    logic [29:0] lon;
    logic        lon_present;
    logic        lon_east;
    logic [3:0]  quality;
    logic [6:0]  sats;
  } fld_t;

  function automatic logic [25:0] lat_weight(input logic [3:0] pos);
    logic [25:0] w;
    case (pos)
      4'd0:    w = 26'd6000000;
      4'd1:    w = 26'd600000;
      4'd2:    w = 26'd100000;
      4'd3:    w = 26'd10000;
      4'd5:    w = 26'd1000;
      4'd6:    w = 26'd100;
      4'd7:    w = 26'd10;
      4'd8:    w = 26'd1;
      default: w = 26'd0;
    endcase
    return w;
  endfunction

  function automatic logic [29:0] lon_weight(input logic [3:0] pos);
    logic [29:0] w;
    case (pos)
      4'd0:    w = 30'd60000000;
      4'd1:    w = 30'd6000000;
      4'd2:    w = 30'd600000;
      4'd3:    w = 30'd100000;
      4'd4:    w = 30'd10000;
      4'd6:    w = 30'd1000;
      4'd7:    w = 30'd100;
      4'd8:    w = 30'd10;
      4'd9:    w = 30'd1;
      default: w = 30'd0;
    endcase
    return w;
  endfunction

  function automatic logic [6:0] frac_weight(input logic [2:0] frac);
    logic [6:0] w;
    case (frac)
      3'd1:    w = 7'd100;
      3'd2:    w = 7'd10;
      3'd3:    w = 7'd1;
      default: w = 7'd0;
    endcase
    return w;
  endfunction

endpackage
`default_nettype wire

>>> src/nmea_gga_position_parser_core.sv
// Top level of the GGA sentence parser: input stage, held coordinates, result register.
// Takes one received byte per cycle while no end byte is stalled. Each byte sits in an input
// register while the field logic updates; on the end byte of a sentence whose first field
// is six characters ending in GGA the result register loads, so a result passes through
// the input register and then the result register. A result waiting at the output blocks
// only an end byte that would produce another result; no other byte stalls.
`timescale 1ns / 1ps
`default_nettype none
module nmea_gga_position_parser_core (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        end_byte_we_i,
  input  wire logic [7:0]  end_byte_i,
  input  wire logic        rx_valid_i,
  output logic             rx_ready_o,
  input  wire logic [7:0]  rx_byte_i,
  output logic             res_valid_o,
  input  wire logic        res_ready_i,
  output logic [6:0]       utc_hour_o,
  output logic [6:0]       utc_minute_o,
  output logic [6:0]       utc_second_o,
  output logic [26:0]      latitude_o,
  output logic [30:0]      longitude_o,
  output logic [27:0]      altitude_mm_o,
  output logic [3:0]       fix_quality_o,
  output logic [6:0]       satellite_count_o
);
  import nggp_pkg::*;

  logic [7:0]  end_byte_q;
  logic        s1_valid_q;
  logic [7:0]  s1_byte_q;
  logic        is_end, match, produce, stall, advance, load;
  tok_t        tok;
  fld_t        fld;
  logic [27:0] alt;
  logic [26:0] held_lat_q, held_lat_d, lat_val;
  logic [30:0] held_lon_q, held_lon_d, lon_val;
  logic        res_valid_q;

  assign is_end     = (s1_byte_q == end_byte_q);
  assign produce    = is_end && match;
  assign stall      = produce && res_valid_q && !res_ready_i;
  assign advance    = s1_valid_q && !stall;
  assign load       = advance && produce;
  assign rx_ready_o = !s1_valid_q || advance;

  nggp_tokenizer u_tokenizer (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .advance_i (advance),
    .is_end_i  (is_end),
    .byte_i    (s1_byte_q),
    .tok_o     (tok),
    .match_o   (match)
  );

  nggp_fields u_fields (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .tok_i  (tok),
    .fld_o  (fld)
  );

  nggp_altitude u_altitude (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .tok_i         (tok),
    .altitude_mm_o (alt)
  );

  assign lat_val    = fld.lat_north ? {1'b0, fld.lat} : 27'd0 - {1'b0, fld.lat};
  assign lon_val    = fld.lon_east ? {1'b0, fld.lon} : 31'd0 - {1'b0, fld.lon};
  assign held_lat_d = (load && fld.lat_present) ? lat_val : held_lat_q;
  assign held_lon_d = (load && fld.lon_present) ? lon_val : held_lon_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      end_byte_q  <= EndByteReset;
      s1_valid_q  <= 1'b0;
      res_valid_q <= 1'b0;
      held_lat_q  <= 27'd0;
      held_lon_q  <= 31'd0;
    end else begin
      if (end_byte_we_i) begin
        end_byte_q <= end_byte_i;
      end
      if (rx_valid_i && rx_ready_o) begin
        s1_valid_q <= 1'b1;
      end else if (advance) begin
        s1_valid_q <= 1'b0;
      end
      if (load) begin
        res_valid_q <= 1'b1;
      end else if (res_ready_i) begin
        res_valid_q <= 1'b0;
      end
      held_lat_q <= held_lat_d;
      held_lon_q <= held_lon_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (rx_valid_i && rx_ready_o) begin
      s1_byte_q <= rx_byte_i;
    end
    if (load) begin
      utc_hour_o        <= fld.hour;
      utc_minute_o      <= fld.minute;
      utc_second_o      <= fld.second;
      latitude_o        <= held_lat_d;
      longitude_o       <= held_lon_d;
      altitude_mm_o     <= alt;
      fix_quality_o     <= fld.quality;
      satellite_count_o <= fld.sats;
    end
  end

  assign res_valid_o = res_valid_q;

  // end byte resets the field position
  a_end_clears: assert property (@(posedge clk_i) disable iff (!rst_ni)
    advance && is_end |=> tok.field == FldType && tok.pos == 8'd0)
    else $error("field position not cleared after end byte");

  // a new result only follows a matched sentence
  a_load_match: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(res_valid_o) |-> $past(match) && $past(is_end))
    else $error("result without a matched sentence end");

  // altitude stays within its saturation bounds
  a_alt_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_o |-> ($signed(altitude_mm_o) <= $signed({1'b0, AltMax}))
                 && ($signed(altitude_mm_o) >= -$signed({1'b0, AltMax})))
    else $error("altitude out of range");

endmodule
`default_nettype wire

>>> src/nggp_tokenizer.sv
// Field and character position tracking, sentence type check.
`timescale 1ns / 1ps
`default_nettype none
module nggp_tokenizer (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        advance_i,
  input  wire logic        is_end_i,
  input  wire logic [7:0]  byte_i,
  output nggp_pkg::tok_t   tok_o,
  output logic             match_o
);
  import nggp_pkg::*;

  logic [3:0] field_q, field_d;
  logic [7:0] pos_q, pos_d;
  logic [1:0] hits_q, hits_d;
  logic       match_q, match_d;
  logic       is_comma, is_digit;

  assign is_comma = (byte_i == CharComma);
  assign is_digit = (byte_i >= CharZero) && (byte_i <= CharNine);

  assign tok_o.take     = advance_i && !is_end_i && !is_comma;
  assign tok_o.done     = advance_i && is_end_i;
  assign tok_o.field    = field_q;
  assign tok_o.pos      = pos_q;
  assign tok_o.ch       = byte_i;
  assign tok_o.is_digit = is_digit;
  assign tok_o.digit    = is_digit ? 4'(byte_i - CharZero) : 4'd0;
  assign match_o        = match_q;

  always_comb begin
    field_d = field_q;
    pos_d   = pos_q;
    hits_d  = hits_q;
    match_d = match_q;
    if (advance_i) begin
      if (is_end_i) begin
        field_d = FldType;
        pos_d   = 8'd0;
        hits_d  = 2'd0;
        match_d = 1'b0;
      end else if (is_comma) begin
        if (field_q == FldType) begin
          match_d = (pos_q == TypeLength) && (hits_q == 2'd3);
        end
        if (field_q != FldLast) begin
          field_d = field_q + 4'd1;
        end
        pos_d = 8'd0;
      end else begin
        if (field_q == FldType) begin
          case (pos_q)
            8'd3:    hits_d = (byte_i == CharG) ? 2'd1 : 2'd0;
            8'd4:    hits_d = (hits_q == 2'd1 && byte_i == CharG) ? 2'd2 : 2'd0;
            8'd5:    hits_d = (hits_q == 2'd2 && byte_i == CharA) ? 2'd3 : 2'd0;
            default: hits_d = hits_q;
          endcase
        end
        if (pos_q != PosLast) begin
          pos_d = pos_q + 8'd1;
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      field_q <= FldType;
      pos_q   <= 8'd0;
      hits_q  <= 2'd0;
      match_q <= 1'b0;
    end else begin
      field_q <= field_d;
      pos_q   <= pos_d;
      hits_q  <= hits_d;
      match_q <= match_d;
    end
  end

endmodule
`default_nettype wire

>>> src/nggp_fields.sv
// Time, coordinate, fix quality and satellite count accumulation.
`timescale 1ns / 1ps
`default_nettype none
module nggp_fields (
  input  wire logic      clk_i,
  input  wire logic      rst_ni,
  input  nggp_pkg::tok_t tok_i,
  output nggp_pkg::fld_t fld_o
);
  import nggp_pkg::*;

  fld_t       fld_q, fld_d;
  logic [6:0] time_term;

  assign time_term = tok_i.pos[0] ? 7'(tok_i.digit) : 7'(tok_i.digit) * 7'd10;
  assign fld_o     = fld_q;

  always_comb begin
    fld_d = fld_q;
    if (tok_i.done) begin
      fld_d = '0;
    end else if (tok_i.take) begin
      case (tok_i.field)
        FldTime: begin
          case (tok_i.pos)
            8'd0, 8'd1: fld_d.hour   = fld_q.hour + time_term;
            8'd2, 8'd3: fld_d.minute = fld_q.minute + time_term;
            8'd4, 8'd5: fld_d.second = fld_q.second + time_term;
            default:    fld_d.hour   = fld_q.hour;
          endcase
        end
        FldLat: begin
          if (tok_i.pos == 8'd0) fld_d.lat_present = 1'b1;
          if (tok_i.pos < 8'd9) begin
            fld_d.lat = fld_q.lat + lat_weight(tok_i.pos[3:0]) * 26'(tok_i.digit);
          end
        end
        FldLatHemi: begin
          if (tok_i.pos == 8'd0) fld_d.lat_north = (tok_i.ch == CharN);
        end
        FldLon: begin
          if (tok_i.pos == 8'd0) fld_d.lon_present = 1'b1;
          if (tok_i.pos < 8'd10) begin
            fld_d.lon = fld_q.lon + lon_weight(tok_i.pos[3:0]) * 30'(tok_i.digit);
          end
        end
        FldLonHemi: begin
          if (tok_i.pos == 8'd0) fld_d.lon_east = (tok_i.ch == CharE);
        end
        FldQuality: begin
          if (tok_i.pos == 8'd0) fld_d.quality = tok_i.digit;
        end
        FldSats: begin
          if (tok_i.pos < 8'd2) fld_d.sats = fld_q.sats * 7'd10 + 7'(tok_i.digit);
        end
        default: fld_d = fld_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fld_q <= '0;
    end else begin
      fld_q <= fld_d;
    end
  end

endmodule
`default_nettype wire

>>> src/nggp_altitude.sv
// Altitude field decoding into saturated signed millimetres.
`timescale 1ns / 1ps
`default_nettype none
module nggp_altitude (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  nggp_pkg::tok_t   tok_i,
  output logic [27:0]      altitude_mm_o
);
  import nggp_pkg::*;

  logic [26:0] acc_q, acc_d;
  logic        neg_q, neg_d;
  logic [2:0]  frac_q, frac_d;
  logic [29:0] int_sum, frac_sum;

  assign int_sum  = 30'(acc_q) * 30'd10 + 30'(tok_i.digit) * 30'd1000;
  assign frac_sum = 30'(acc_q) + 30'(tok_i.digit) * 30'(frac_weight(frac_q));

  assign altitude_mm_o = neg_q ? 28'd0 - 28'(acc_q) : 28'(acc_q);

  always_comb begin
    acc_d  = acc_q;
    neg_d  = neg_q;
    frac_d = frac_q;
    if (tok_i.done) begin
      acc_d  = 27'd0;
      neg_d  = 1'b0;
      frac_d = AltInt;
    end else if (tok_i.take && tok_i.field == FldAlt && frac_q != AltStop) begin
      if (tok_i.pos == 8'd0 && (tok_i.ch == CharPlus || tok_i.ch == CharMinus)) begin
        neg_d = (tok_i.ch == CharMinus);
      end else if (tok_i.is_digit) begin
        if (frac_q == AltInt) begin
          acc_d = (int_sum > 30'(AltMax)) ? AltMax : int_sum[26:0];
        end else if (frac_q < AltFracEnd) begin
          acc_d  = (frac_sum > 30'(AltMax)) ? AltMax : frac_sum[26:0];
          frac_d = frac_q + 3'd1;
        end
      end else if (tok_i.ch == CharDot && frac_q == AltInt) begin
        frac_d = 3'd1;
      end else begin
        frac_d = AltStop;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      acc_q  <= 27'd0;
      neg_q  <= 1'b0;
      frac_q <= AltInt;
    end else begin
      acc_q  <= acc_d;
      neg_q  <= neg_d;
      frac_q <= frac_d;
    end
  end

endmodule
`default_nettype wire

>>> sim/nggp_fix_checker.sv
`timescale 1ns / 1ps
// Position fix checker for the GGA parser: follows accepted bytes, predicts fixes, compares.
module nggp_fix_checker
  import nggp_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        end_byte_we_i,
  input  logic [7:0]  end_byte_i,
  input  logic        rx_valid_i,
  input  logic        rx_ready_i,
  input  logic [7:0]  rx_byte_i,
  input  logic        res_valid_i,
  input  logic        res_ready_i,
  input  logic [6:0]  utc_hour_i,
  input  logic [6:0]  utc_minute_i,
  input  logic [6:0]  utc_second_i,
  input  logic [26:0] latitude_i,
  input  logic [30:0] longitude_i,
  input  logic [27:0] altitude_mm_i,
  input  logic [3:0]  fix_quality_i,
  input  logic [6:0]  satellite_count_i,
  output int          fail_count_o,
  output int          pending_o
);

  typedef struct packed {
    logic [6:0]  hour;
    logic [6:0]  minute;
    logic [6:0]  second;
    logic [26:0] lat;
    logic [30:0] lon;
    logic [27:0] alt;
    logic [3:0]  quality;
    logic [6:0]  sats;
  } gga_fix_t;

  localparam logic [1:0] TypeNone = 2'd0;
  localparam logic [1:0] TypeG    = 2'd1;
  localparam logic [1:0] TypeGG   = 2'd2;
  localparam logic [1:0] TypeGGA  = 2'd3;

  localparam logic [2:0] AltFirstFrac = 3'd1;
  localparam int LatDegDigits = 2;
  localparam int LonDegDigits = 3;
  localparam int MaxReports   = 10;

  gga_fix_t    fix_q[$];
  logic [7:0]  end_byte_q;
  logic [3:0]  fld_no;
  logic [7:0]  pos;
  logic        type_ok;
  logic [1:0]  type_seen;
  logic [25:0] lat_acc;
  logic        lat_seen;
  logic        lat_north;
  logic [29:0] lon_acc;
  logic        lon_seen;
  logic        lon_east;
  logic [26:0] held_lat;
  logic [30:0] held_lon;
  logic [6:0]  hour_acc;
  logic [6:0]  min_acc;
  logic [6:0]  sec_acc;
  logic [26:0] alt_acc;
  logic        alt_neg;
  logic [2:0]  alt_frac;
  logic [3:0]  quality;
  logic [6:0]  sats;
  int          mismatches;

  function automatic int unsigned pow10(input int n);
    int unsigned r;
    r = 1;
    for (int i = 0; i < n; i++) r = r * 10;
    return r;
  endfunction

  // digit weight in ten-thousandths of a minute; nd is the number of degree digits
  function automatic int unsigned coord_scale(input int p, input int nd);
    int unsigned r;
    r = 0;
    if (p < nd) begin
      r = 600000 * pow10(nd - 1 - p);
    end else if (p < nd + 2) begin
      r = 10000 * pow10(nd + 1 - p);
    end else if (p > nd + 2 && p < nd + 7) begin
      r = pow10(nd + 6 - p);
    end
    return r;
  endfunction

  function automatic logic [26:0] alt_clip(input longint unsigned v);
    return (v > AltMax) ? AltMax : v[26:0];
  endfunction

  function automatic string fix_text(input gga_fix_t f);
    return $sformatf("%0d:%0d:%0d lat %0d lon %0d alt %0d fix %0d sats %0d",
                     f.hour, f.minute, f.second, $signed(f.lat), $signed(f.lon),
                     $signed(f.alt), f.quality, f.sats);
  endfunction

  task automatic start_sentence();
    fld_no    = FldType;
    pos       = '0;
    type_ok   = 1'b0;
    type_seen = TypeNone;
    lat_acc   = '0;
    lat_seen  = 1'b0;
    lat_north = 1'b0;
    lon_acc   = '0;
    lon_seen  = 1'b0;
    lon_east  = 1'b0;
    hour_acc  = '0;
    min_acc   = '0;
    sec_acc   = '0;
    alt_acc   = '0;
    alt_neg   = 1'b0;
    alt_frac  = AltInt;
    quality   = '0;
    sats      = '0;
  endtask

  task automatic alt_char(input logic [7:0] c, input logic [3:0] d);
    if (alt_frac != AltStop) begin
      if (pos == '0 && (c == CharPlus || c == CharMinus)) begin
        alt_neg = (c == CharMinus);
      end else if (c >= CharZero && c <= CharNine) begin
        if (alt_frac == AltInt) begin
          alt_acc = alt_clip(longint'(alt_acc) * 10 + longint'(d) * 1000);
        end else if (alt_frac < AltFracEnd) begin
          alt_acc = alt_clip(longint'(alt_acc) + longint'(d) * pow10(3 - int'(alt_frac)));
          alt_frac = alt_frac + 3'd1;
        end
      end else if (c == CharDot && alt_frac == AltInt) begin
        alt_frac = AltFirstFrac;
      end else begin
        alt_frac = AltStop;
      end
    end
  endtask

  task automatic parse_byte(input logic [7:0] c);
    logic [3:0] d;
    logic [6:0] step;
    gga_fix_t   fix;
    d = (c >= CharZero && c <= CharNine) ? 4'(c - CharZero) : 4'd0;
    if (c == end_byte_q) begin
      if (type_ok) begin
        if (lat_seen) held_lat = lat_north ? {1'b0, lat_acc} : -{1'b0, lat_acc};
        if (lon_seen) held_lon = lon_east ? {1'b0, lon_acc} : -{1'b0, lon_acc};
        fix.hour    = hour_acc;
        fix.minute  = min_acc;
        fix.second  = sec_acc;
        fix.lat     = held_lat;
        fix.lon     = held_lon;
        fix.alt     = alt_neg ? -{1'b0, alt_acc} : {1'b0, alt_acc};
        fix.quality = quality;
        fix.sats    = sats;
        fix_q.push_back(fix);
      end
      start_sentence();
    end else if (c == CharComma) begin
      if (fld_no == FldType) type_ok = (pos == TypeLength) && (type_seen == TypeGGA);
      if (fld_no != FldLast) fld_no = fld_no + 4'd1;
      pos = '0;
    end else begin
      case (fld_no)
        FldType: begin
          if (pos == 8'd3) begin
            type_seen = (c == CharG) ? TypeG : TypeNone;
          end else if (pos == 8'd4) begin
            type_seen = (type_seen == TypeG && c == CharG) ? TypeGG : TypeNone;
          end else if (pos == 8'd5) begin
            type_seen = (type_seen == TypeGG && c == CharA) ? TypeGGA : TypeNone;
          end
        end
        FldTime: begin
          if (pos < 8'd6) begin
            step = pos[0] ? 7'(d) : 7'(d) * 7'd10;
            case (pos[2:1])
              2'd0:    hour_acc = hour_acc + step;
              2'd1:    min_acc = min_acc + step;
              default: sec_acc = sec_acc + step;
            endcase
          end
        end
        FldLat: begin
          if (pos == '0) lat_seen = 1'b1;
          lat_acc = lat_acc + 26'(d * coord_scale(int'(pos), LatDegDigits));
        end
        FldLatHemi: begin
          if (pos == '0) lat_north = (c == CharN);
        end
        FldLon: begin
          if (pos == '0) lon_seen = 1'b1;
          lon_acc = lon_acc + 30'(d * coord_scale(int'(pos), LonDegDigits));
        end
        FldLonHemi: begin
          if (pos == '0) lon_east = (c == CharE);
        end
        FldQuality: begin
          if (pos == '0) quality = d;
        end
        FldSats: begin
          if (pos < 8'd2) sats = 7'(sats * 10 + d);
        end
        FldAlt: alt_char(c, d);
        default: ;
      endcase
      if (pos != PosLast) pos = pos + 8'd1;
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    gga_fix_t got;
    gga_fix_t want;
    if (!rst_ni) begin
      end_byte_q = EndByteReset;
      held_lat   = '0;
      held_lon   = '0;
      mismatches = 0;
      fix_q.delete();
      start_sentence();
    end else begin
      if (end_byte_we_i) end_byte_q = end_byte_i;
      if (res_valid_i && res_ready_i) begin
        got = {utc_hour_i, utc_minute_i, utc_second_i, latitude_i, longitude_i,
               altitude_mm_i, fix_quality_i, satellite_count_i};
        if (fix_q.size() == 0) begin
          mismatches++;
          if (mismatches <= MaxReports)
            $display("%0t: fix with none expected: %s", $time, fix_text(got));
        end else begin
          want = fix_q.pop_front();
          if (got !== want) begin
            mismatches++;
            if (mismatches <= MaxReports) begin
              $display("%0t: fix mismatch", $time);
              $display("  expected %s", fix_text(want));
              $display("  actual   %s", fix_text(got));
            end
          end
        end
      end
      if (rx_valid_i && rx_ready_i) parse_byte(rx_byte_i);
    end
    fail_count_o = mismatches;
    pending_o    = fix_q.size();
  end

endmodule

>>> sim/tb_nmea_gga_position_parser_core.sv
`timescale 1ns / 1ps
// Testbench top for the GGA parser: sentence stimulus, end byte settings and back-pressure.
module tb_nmea_gga_position_parser_core;
  import nggp_pkg::*;

  localparam int ResetCycles  = 3;
  localparam int SettleCycles = 8;
  localparam int ByteTarget   = 1950;
  localparam int NumPhases    = 5;
  localparam longint RunLimitNs = 64'd20_000_000;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        end_byte_we = 1'b0;
  logic [7:0]  end_byte_val = EndByteReset;
  logic        rx_valid = 1'b0;
  logic [7:0]  rx_byte = 8'd0;
  logic        res_ready = 1'b0;
  logic        rx_ready;
  logic        res_valid;
  logic [6:0]  utc_hour;
  logic [6:0]  utc_minute;
  logic [6:0]  utc_second;
  logic [26:0] latitude;
  logic [30:0] longitude;
  logic [27:0] altitude_mm;
  logic [3:0]  fix_quality;
  logic [6:0]  satellite_count;
  int          fail_count;
  int          pending;

  logic [7:0]  cur_end = EndByteReset;
  logic [7:0]  line_q[$];
  int          bytes_sent = 0;
  int          ready_hold = 0;

  logic [7:0]  phase_end[NumPhases] = '{8'hFF, 8'h00, CharComma, 8'h0D, EndByteReset};
  int          phase_bytes[NumPhases] = '{250, 250, 100, 250, 0};

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  nmea_gga_position_parser_core i_dut (
    .clk_i             (clk),
    .rst_ni            (rst_n),
    .end_byte_we_i     (end_byte_we),
    .end_byte_i        (end_byte_val),
    .rx_valid_i        (rx_valid),
    .rx_ready_o        (rx_ready),
    .rx_byte_i         (rx_byte),
    .res_valid_o       (res_valid),
    .res_ready_i       (res_ready),
    .utc_hour_o        (utc_hour),
    .utc_minute_o      (utc_minute),
    .utc_second_o      (utc_second),
    .latitude_o        (latitude),
    .longitude_o       (longitude),
    .altitude_mm_o     (altitude_mm),
    .fix_quality_o     (fix_quality),
    .satellite_count_o (satellite_count)
  );

  nggp_fix_checker i_checker (
    .clk_i             (clk),
    .rst_ni            (rst_n),
    .end_byte_we_i     (end_byte_we),
    .end_byte_i        (end_byte_val),
    .rx_valid_i        (rx_valid),
    .rx_ready_i        (rx_ready),
    .rx_byte_i         (rx_byte),
    .res_valid_i       (res_valid),
    .res_ready_i       (res_ready),
    .utc_hour_i        (utc_hour),
    .utc_minute_i      (utc_minute),
    .utc_second_i      (utc_second),
    .latitude_i        (latitude),
    .longitude_i       (longitude),
    .altitude_mm_i     (altitude_mm),
    .fix_quality_i     (fix_quality),
    .satellite_count_i (satellite_count),
    .fail_count_o      (fail_count),
    .pending_o         (pending)
  );

  // result back-pressure: short toggles, long open stretches, occasional long stalls
  always @(posedge clk) begin
    int r;
    if (ready_hold > 0) begin
      ready_hold <= ready_hold - 1;
    end else begin
      r = $urandom_range(0, 99);
      if (r < 55) begin
        res_ready  <= 1'b1;
        ready_hold <= $urandom_range(0, 7);
      end else if (r < 85) begin
        res_ready  <= 1'b0;
        ready_hold <= $urandom_range(0, 3);
      end else if (r < 95) begin
        res_ready  <= 1'b1;
        ready_hold <= $urandom_range(50, 200);
      end else begin
        res_ready  <= 1'b0;
        ready_hold <= $urandom_range(10, 60);
      end
    end
  end

  function automatic logic [7:0] any_char();
    logic [7:0] c;
    do c = 8'($urandom_range(0, 255)); while (c == CharComma || c == cur_end);
    return c;
  endfunction

  task automatic add_text(input string s);
    for (int i = 0; i < s.len(); i++) line_q.push_back(s[i]);
  endtask

  task automatic add_digits(input int n);
    repeat (n) begin
      if ($urandom_range(0, 19) == 0) line_q.push_back(any_char());
      else line_q.push_back(CharZero + 8'($urandom_range(0, 9)));
    end
  endtask

  task automatic add_hemi(input logic [7:0] plus_c, input logic [7:0] minus_c);
    int r;
    r = $urandom_range(0, 9);
    if (r < 4) line_q.push_back(plus_c);
    else if (r < 8) line_q.push_back(minus_c);
    else if (r == 9) line_q.push_back(any_char());
  endtask

  task automatic add_gga_body();
    int r;
    add_text("$G");
    line_q.push_back(($urandom_range(0, 3) == 0) ? any_char() : "P");
    add_text("GGA,");
    r = $urandom_range(0, 19);
    if (r > 3) begin
      add_digits(6);
      if (r[0]) begin
        add_text(".");
        add_digits(2);
      end
    end else if (r > 1) begin
      add_digits($urandom_range(0, 5));
    end
    add_text(",");
    if ($urandom_range(0, 6) != 0) begin
      add_digits(($urandom_range(0, 3) == 0) ? $urandom_range(0, 5) : 4);
      line_q.push_back(($urandom_range(0, 7) == 0) ? any_char() : CharDot);
      add_digits(($urandom_range(0, 3) == 0) ? $urandom_range(0, 5) : 4);
    end
    add_text(",");
    add_hemi(CharN, "S");
    add_text(",");
    if ($urandom_range(0, 6) != 0) begin
      add_digits(($urandom_range(0, 3) == 0) ? $urandom_range(0, 6) : 5);
      line_q.push_back(($urandom_range(0, 7) == 0) ? any_char() : CharDot);
      add_digits(($urandom_range(0, 3) == 0) ? $urandom_range(0, 5) : 4);
    end
    add_text(",");
    add_hemi(CharE, "W");
    add_text(",");
    add_digits(($urandom_range(0, 9) == 0) ? 0 : 1);
    add_text(",");
    add_digits($urandom_range(0, 3));
    add_text(",0.9,");
    r = $urandom_range(0, 2);
    if (r == 1) line_q.push_back(CharPlus);
    if (r == 2) line_q.push_back(CharMinus);
    add_digits(($urandom_range(0, 9) == 0) ? $urandom_range(6, 10) : $urandom_range(0, 4));
    r = $urandom_range(0, 19);
    if (r < 14) begin
      line_q.push_back(CharDot);
      add_digits($urandom_range(0, 5));
    end else if (r < 17) begin
      line_q.push_back(any_char());
      add_digits($urandom_range(0, 2));
    end
    add_text(",M,46.9,M,,*");
    add_digits(2);
    if ($urandom_range(0, 1) == 1) line_q.push_back(8'h0D);
  endtask

  task automatic send_byte(input logic [7:0] b, input bit may_idle);
    int gap;
    int r;
    gap = 0;
    if (may_idle) begin
      r = $urandom_range(0, 99);
      if (r >= 98) gap = $urandom_range(20, 40);
      else if (r >= 90) gap = $urandom_range(4, 8);
      else if (r >= 70) gap = $urandom_range(1, 3);
    end
    if (gap > 0) begin
      rx_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    rx_valid <= 1'b1;
    rx_byte  <= b;
    do @(posedge clk); while (!rx_ready);
    bytes_sent++;
  endtask

  task automatic send_line();
    bit steady;
    steady = ($urandom_range(0, 3) == 0);
    line_q.push_back(cur_end);
    foreach (line_q[i]) send_byte(line_q[i], !steady);
    line_q.delete();
  endtask

  task automatic send_text(input string s);
    add_text(s);
    send_line();
  endtask

  task automatic random_sentence();
    int kind;
    int keep;
    kind = $urandom_range(0, 99);
    if (kind < 88) begin
      add_gga_body();
      if (kind >= 72 && kind < 76) line_q[$urandom_range(3, 5)] = any_char();
      else if (kind >= 76 && kind < 80) line_q.insert(1, any_char());
      else if (kind >= 80) begin
        keep = $urandom_range(1, line_q.size());
        while (line_q.size() > keep) void'(line_q.pop_back());
      end
    end else if (kind < 96) begin
      repeat ($urandom_range(1, 40)) line_q.push_back(8'($urandom_range(0, 255)));
    end else if (kind < 98) begin
      add_text("$GPGGA");
      repeat ($urandom_range(16, 22)) begin
        line_q.push_back(CharComma);
        add_digits($urandom_range(0, 3));
      end
    end else begin
      add_text("$GPGGA,010203,1234.5678,N,12345.6789,E,1,07,0.9,");
      add_digits($urandom_range(250, 270));
      add_text(",M");
    end
    send_line();
  endtask

  task automatic run_random(input int budget);
    int start;
    start = bytes_sent;
    while (bytes_sent - start < budget) random_sentence();
  endtask

  // sender holds off until every fix is out and the pipeline has drained
  task automatic wait_idle();
    rx_valid <= 1'b0;
    do @(posedge clk); while (pending != 0);
    repeat (SettleCycles) @(posedge clk);
  endtask

  task automatic write_end_byte(input logic [7:0] v);
    end_byte_we  <= 1'b1;
    end_byte_val <= v;
    cur_end = v;
    @(posedge clk);
    end_byte_we <= 1'b0;
  endtask

  initial begin
    repeat (ResetCycles) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    send_text("$GPGGA,123519,4807.038,N,01131.000,E,1,08,0.9,545.4,M,46.9,M,,*47");
    send_text("$GPGGA,999999,9999.9999,N,99999.9999,E,9,99,0.5,99999.999,M,,M,,*00");
    send_text("$GNGGA,999999,9999.9999,S,99999.9999,W,9,99,9,-99999999.9999,M,,*00");
    send_text("$GPGGA,000000,,,,,0,,,,M,,M,,*00");
    send_text("$GPGGA,1a2:3 ,4807X0380,N,01131Y0000,E,,7,,+12.34567,M,,*00");
    send_text("$GPGGA,010203,1234.5678,,12345.6789,,1,12,1,-,M");
    send_text("$GPGGA,010203,1234.5678");
    send_text("$GPGGA,,,,,,,,,12.3e4");
    send_text("$GPGGA,,,,,,,,,1.2.3");
    send_text("$GPGGA,,,,,,,,,123456789");
    send_text("$GPGGA,,,,,,,,,+0.0001");
    send_text("$GPRMC,123519,A,4807.038,N");
    send_text("$GPGGAA,1,2,N");
    send_text("GGA,1,2");
    send_text("$GPGG");
    send_text("$GPGGA");
    send_text("$GPGGA,1,2,N,3,E,4,5,6,7,8,9,10,11,12,13,14,15,16,17,18");
    add_text("$GPGGA,0102");
    line_q.push_back(8'h00);
    add_text("03,4807.038,N,,,2,1");
    send_line();

    run_random(300);
    for (int i = 0; i < NumPhases; i++) begin
      wait_idle();
      write_end_byte(phase_end[i]);
      if (i == NumPhases - 1) begin
        while (bytes_sent < ByteTarget) random_sentence();
      end else begin
        run_random(phase_bytes[i]);
      end
    end
    wait_idle();

    if (fail_count == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

  initial begin
    #(RunLimitNs);
    $display("FAILED: results differ");
    $finish;
  end

endmodule
